/* rtl/edac_pkg.sv */
// Shared types and constants for the debounced edge alert block.
`default_nettype none

package edac_pkg;

  localparam int unsigned MAX_LANES = 8;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd50;
  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd60000;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTIFY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            commit;
    logic [CH_W-1:0] idx;
    logic            emit;
    logic            emit_last;
  } edac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic alert;
    logic hold_valid;
    logic out_free;
  } edac_sts_t;

endpackage

`default_nettype wire

/* rtl/edac_if.sv */
// Scan and alert channel interfaces.
`default_nettype none

interface edac_in_if import edac_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] levels;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output levels, output now_ms, input ready);
  modport sink   (input valid, input levels, input now_ms, output ready);
endinterface

interface edac_out_if import edac_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] channel;
  logic            level;
  logic            last_alert;

  modport source (output valid, output channel, output level, output last_alert, input ready);
  modport sink   (input valid, input channel, input level, input last_alert, output ready);
endinterface

`default_nettype wire

/* rtl/digital_edge_alert_debounce_cooldown.sv */
// Top level of the debounced edge alert block with per-channel cooldown.
//
// in_if carries one scan per item: the level of every channel and a
// millisecond timestamp. out_if carries one item per alert, in ascending
// channel order, with last_alert set on the final alert of a scan; a scan
// that raises no alert gives no output item.
// The cfg_ port writes trigger_mask, notify_mask, debounce_ms and
// cooldown_ms by index; write only while no scan is busy.
// After a scan is accepted the block visits each channel in turn (LANES
// is min(CHANNELS, 8)), comparing both timers in one pass, and then
// releases the held alert before it is ready for the next scan.
// An alert is held until the next alerting channel of the scan is evaluated
// and reaches out_if in the cycle after; the final one of a scan appears
// in the cycle the block is ready again.
// A stalled receiver holds the output register; the scan then pauses on
// the next alerting channel until the register is taken, and the block
// accepts no new scan until the current one has been fully handed over.
// Reset clears all channel state, empties the output and sets the
// registers to masks zero, debounce 50 ms and cooldown 60000 ms.
`default_nettype none

module digital_edge_alert_debounce_cooldown import edac_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  edac_in_if.sink                   in_if,
  edac_out_if.source                out_if,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned LANES = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

  logic [MASK_W-1:0] trigger_r;
  logic [MASK_W-1:0] notify_r;
  logic [TIME_W-1:0] debounce_r;
  logic [TIME_W-1:0] cooldown_r;

  edac_cmd_t cmd;
  edac_sts_t sts;
  logic      in_ready;

  assign in_if.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r  <= '0;
      notify_r   <= '0;
      debounce_r <= DEBOUNCE_RESET;
      cooldown_r <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER:  trigger_r  <= cfg_wdata[MASK_W-1:0];
        REG_NOTIFY:   notify_r   <= cfg_wdata[MASK_W-1:0];
        REG_DEBOUNCE: debounce_r <= cfg_wdata[TIME_W-1:0];
        REG_COOLDOWN: cooldown_r <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  edac_ctrl #(
    .LANES (LANES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edac_dp #(
    .LANES (LANES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .levels       (in_if.levels),
    .now_ms       (in_if.now_ms),
    .trigger_mask (trigger_r),
    .notify_mask  (notify_r),
    .debounce_ms  (debounce_r),
    .cooldown_ms  (cooldown_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_if       (out_if)
  );

endmodule

`default_nettype wire

/* rtl/edac_ctrl.sv */
// Scan sequencer: walks the channels of one item and schedules alert output.
`default_nettype none

module edac_ctrl import edac_pkg::*; #(
  parameter int unsigned LANES = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire edac_sts_t sts,
  output edac_cmd_t      cmd
);

  localparam int unsigned LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LANE_W-1:0] LAST_IDX = LANE_W'(LANES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] idx_r, idx_nxt;
  logic              stall;

  assign in_ready = (state_r == S_IDLE);
  // a new alert would push out the held one, so the output register must be free
  assign stall = sts.alert && sts.hold_valid && !sts.out_free;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.idx       = CH_W'(idx_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          cmd.commit = 1'b1;
          cmd.emit   = sts.alert && sts.hold_valid;
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!sts.hold_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_scan_ends_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && idx_r == LAST_IDX && cmd.commit) |=> (state_r == S_FLUSH))
    else $error("scan did not move to flush after the last channel");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while the output register is occupied");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= LAST_IDX))
    else $error("channel index beyond lane count");

endmodule

`default_nettype wire

/* rtl/edac_dp.sv */
// Per-channel debounce state, alert hold buffer and output register.
`default_nettype none

module edac_dp import edac_pkg::*; #(
  parameter int unsigned LANES = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [MASK_W-1:0] levels,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [MASK_W-1:0] trigger_mask,
  input  wire logic [MASK_W-1:0] notify_mask,
  input  wire logic [TIME_W-1:0] debounce_ms,
  input  wire logic [TIME_W-1:0] cooldown_ms,
  input  wire edac_cmd_t         cmd,
  output edac_sts_t              sts,
  edac_out_if.source             out_if
);

  localparam int unsigned LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0]  lvl_r;
  logic [TIME_W-1:0] now_r;

  logic              stable_r [LANES];
  logic              pend_r   [LANES];
  logic [TIME_W-1:0] since_r  [LANES];
  logic [TIME_W-1:0] last_r   [LANES];

  logic              hold_valid_r;
  logic              hold_valid_nxt;
  logic [CH_W-1:0]   hold_ch_r;
  logic              hold_lvl_r;

  logic              out_valid_r;
  logic [CH_W-1:0]   out_ch_r;
  logic              out_lvl_r;
  logic              out_last_r;

  logic [LANE_W-1:0] sel;
  logic              cur_lvl;
  logic              changed;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] quiet;
  logic              confirm;
  logic              alert;

  assign sel     = cmd.idx[LANE_W-1:0];
  assign cur_lvl = lvl_r[sel];
  assign changed = (cur_lvl != stable_r[sel]);
  // wrapping differences against the scan timestamp
  assign age     = now_r - since_r[sel];
  assign quiet   = now_r - last_r[sel];
  assign confirm = !changed && pend_r[sel] && (age >= debounce_ms)
                   && (cur_lvl == trigger_mask[sel]) && (quiet >= cooldown_ms);
  assign alert   = confirm && notify_mask[sel];

  // a new alert refills the hold buffer in the cycle the old one leaves
  assign hold_valid_nxt = (cmd.commit && alert) || (hold_valid_r && !cmd.emit);

  assign sts.alert      = alert;
  assign sts.hold_valid = hold_valid_r;
  assign sts.out_free   = !out_valid_r || out_if.ready;

  assign out_if.valid      = out_valid_r;
  assign out_if.channel    = out_ch_r;
  assign out_if.level      = out_lvl_r;
  assign out_if.last_alert = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        stable_r[i] <= 1'b0;
        pend_r[i]   <= 1'b0;
        since_r[i]  <= '0;
        last_r[i]   <= '0;
      end
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      hold_valid_r <= hold_valid_nxt;
      if (cmd.commit) begin
        if (changed) begin
          stable_r[sel] <= cur_lvl;
          since_r[sel]  <= now_r;
          pend_r[sel]   <= 1'b1;
        end else if (confirm) begin
          pend_r[sel] <= 1'b0;
          if (alert) begin
            last_r[sel] <= now_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl_r <= levels[LANES-1:0];
      now_r <= now_ms;
    end
    if (cmd.emit) begin
      out_ch_r   <= hold_ch_r;
      out_lvl_r  <= hold_lvl_r;
      out_last_r <= cmd.emit_last;
    end
    // park the newest alert until it is known whether another follows
    if (cmd.commit && alert) begin
      hold_ch_r  <= cmd.idx;
      hold_lvl_r <= cur_lvl;
    end
  end

  a_held_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && alert && hold_valid_r) |-> cmd.emit)
    else $error("held alert overwritten without being emitted");

  a_flush_empties_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> (!hold_valid_r && out_valid_r && out_last_r))
    else $error("final alert did not leave the hold buffer");

  a_last_only_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.commit) |-> !cmd.emit_last)
    else $error("final marker set while channels remain");

endmodule

`default_nettype wire

/* sim/digital_edge_alert_debounce_cooldown_tb.sv */
// Self-checking testbench for the debounced edge alert block with per-channel cooldown.
`default_nettype none

module digital_edge_alert_debounce_cooldown_tb;
  import edac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned LANES    = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;
  localparam int unsigned SETTLE   = 2 * LANES + 4;
  localparam int unsigned HOLD_OFF = 400;

  typedef struct packed {
    logic [MASK_W-1:0] levels;
    logic [TIME_W-1:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            level;
    logic            last;
  } alert_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  edac_in_if  scan_if ();
  edac_out_if alert_if ();

  digital_edge_alert_debounce_cooldown #(.CHANNELS(CHANNELS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (scan_if),
    .out_if    (alert_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's registers and per-channel state
  logic [MASK_W-1:0] trig_mask    = '0;
  logic [MASK_W-1:0] notify_mask  = '0;
  logic [TIME_W-1:0] debounce_ms  = DEBOUNCE_RESET;
  logic [TIME_W-1:0] cooldown_ms  = COOLDOWN_RESET;
  logic [7:0]        stable_lvl   = '0;
  logic [7:0]        pend_on      = '0;
  logic [TIME_W-1:0] pend_start [8];
  logic [TIME_W-1:0] fired_at   [8];

  scan_t  pending_scans [$];
  alert_t due_alerts    [$];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  logic        hold_on;
  int          errors       = 0;
  int          scans_taken  = 0;
  int          alerts_seen  = 0;

  initial begin
    for (int i = 0; i < 8; i++) begin
      pend_start[i] = '0;
      fired_at[i]   = '0;
    end
  end

  // work out the alerts one scan raises and queue them in channel order
  function automatic void predict_alerts(input logic [MASK_W-1:0] lv,
                                         input logic [TIME_W-1:0] now);
    alert_t            hits [$];
    alert_t            a;
    logic              lvl;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] quiet;
    for (int i = 0; i < LANES; i++) begin
      lvl   = lv[i];
      held  = now - pend_start[i];
      quiet = now - fired_at[i];
      if (lvl != stable_lvl[i]) begin
        stable_lvl[i] = lvl;
        pend_start[i] = now;
        pend_on[i]    = 1'b1;
      end else if (pend_on[i] && held >= debounce_ms && lvl == trig_mask[i] &&
                   quiet >= cooldown_ms) begin
        if (notify_mask[i]) begin
          a.channel   = i[CH_W-1:0];
          a.level     = lvl;
          a.last      = 1'b0;
          hits.push_back(a);
          fired_at[i] = now;
        end
        pend_on[i] = 1'b0;
      end
    end
    if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
    foreach (hits[k]) due_alerts.push_back(hits[k]);
  endfunction

  // scan driver
  always @(posedge clk) begin
    scan_t s;
    if (!rst_n) begin
      scan_if.valid <= 1'b0;
    end else if (!scan_if.valid || scan_if.ready) begin
      if (pending_scans.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s = pending_scans.pop_front();
        scan_if.valid  <= 1'b1;
        scan_if.levels <= s.levels;
        scan_if.now_ms <= s.now_ms;
      end else begin
        scan_if.valid <= 1'b0;
      end
    end
  end

  // alert receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      alert_if.ready <= 1'b0;
    end else begin
      alert_if.ready <= !hold_on && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // predict on each accepted scan, check each accepted alert
  always @(posedge clk) begin
    alert_t want;
    if (rst_n) begin
      if (scan_if.valid && scan_if.ready) begin
        predict_alerts(scan_if.levels, scan_if.now_ms);
        scans_taken++;
      end
      if (alert_if.valid && alert_if.ready) begin
        alerts_seen++;
        if (due_alerts.size() == 0) begin
          $display("%0t: expected no alert, got channel=%0d level=%0d last=%0d", $time,
                   alert_if.channel, alert_if.level, alert_if.last_alert);
          errors++;
        end else begin
          want = due_alerts.pop_front();
          if (alert_if.channel !== want.channel || alert_if.level !== want.level ||
              alert_if.last_alert !== want.last) begin
            $display("%0t: expected ch=%0d lvl=%0d last=%0d, got ch=%0d lvl=%0d last=%0d",
                     $time, want.channel, want.level, want.last,
                     alert_if.channel, alert_if.level, alert_if.last_alert);
            errors++;
          end
        end
      end
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TRIGGER:  trig_mask   = val[MASK_W-1:0];
      REG_NOTIFY:   notify_mask = val[MASK_W-1:0];
      REG_DEBOUNCE: debounce_ms = val;
      REG_COOLDOWN: cooldown_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [7:0] trig, input logic [7:0] notif,
                         input logic [31:0] deb, input logic [31:0] cool);
    set_reg(REG_TRIGGER, {24'd0, trig});
    set_reg(REG_NOTIFY, {24'd0, notif});
    set_reg(REG_DEBOUNCE, deb);
    set_reg(REG_COOLDOWN, cool);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_scan(input logic [7:0] lv, input logic [31:0] now);
    scan_t s;
    s.levels = lv;
    s.now_ms = now;
    pending_scans.push_back(s);
  endtask

  // wait for every item to go through, then let a scan with no alert finish
  task automatic drain();
    while (pending_scans.size() != 0 || scan_if.valid || due_alerts.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  lv;
    logic [7:0]  flip;
    logic [31:0] stamp;
    int unsigned step_max;
    int unsigned tx_pct;
    int unsigned rx_pct;
    int          n_items;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_TRIGGER;
    cfg_wdata      = '0;
    scan_if.valid  = 1'b0;
    scan_if.levels = '0;
    scan_if.now_ms = '0;
    alert_if.ready = 1'b0;
    hold_on        = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: debounce and cooldown keep their reset values here
    set_reg(REG_TRIGGER, 32'h0000_00F0);
    set_reg(REG_NOTIFY, 32'h0000_003C);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    add_scan(8'hFF, 32'd0);            // every channel changes
    add_scan(8'hFF, 32'd49);           // one short of the debounce time
    add_scan(8'hFF, 32'd50);           // debounced, cooldown from zero not yet over
    add_scan(8'hFF, 32'd60000);        // first alerts, quiet channels just cleared
    add_scan(8'hFF, 32'd60001);        // stable, channels 0 to 3 still pending
    add_scan(8'h00, 32'd60002);
    add_scan(8'h00, 32'd60052);        // low-level triggers fire
    add_scan(8'h0F, 32'd60100);
    add_scan(8'h0F, 32'd120100);       // trigger mismatch keeps pending
    add_scan(8'hFF, 32'hFFFF_FFF0);
    add_scan(8'hFF, 32'h0000_0030);    // timestamp wraps
    add_scan(8'hFF, 32'hFFFF_FFFF);
    add_scan(8'h00, 32'hFFFF_FFFF);
    add_scan(8'h00, 32'h0000_FFFF);    // cooldown still running on some channels
    add_scan(8'h00, 32'h0002_0000);
    add_scan(8'hAA, 32'h0002_0000);
    add_scan(8'h55, 32'h0002_0001);
    add_scan(8'h55, 32'h0002_0100);
    add_scan(8'h55, 32'h0005_0000);
    drain();

    stamp = 32'd1000;
    lv    = 8'h55;
    for (int phase = 0; phase < 8; phase++) begin
      n_items = 30;
      case (phase)
        0: begin set_all(8'($urandom), 8'hFF, 32'd0, 32'd0); tx_pct = 0; rx_pct = 0;
                 step_max = 4; end
        1: begin set_all(8'h00, 8'($urandom), 32'd3, 32'd10); tx_pct = 71; rx_pct = 0;
                 step_max = 8; end
        2: begin set_all(8'hFF, 8'hFF, 32'd10, 32'd40); tx_pct = 0; rx_pct = 71;
                 step_max = 16; end
        3: begin set_all(8'($urandom), 8'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                 tx_pct = 23; rx_pct = 23; step_max = 8; end
        4: begin set_all(8'($urandom), 8'hFF, 32'd0, 32'd0); tx_pct = 0; rx_pct = 0;
                 step_max = 2; end
        5: begin set_all(8'($urandom), 8'($urandom), DEBOUNCE_RESET, COOLDOWN_RESET);
                 tx_pct = 23; rx_pct = 23; step_max = 30000; stamp = 32'hFFFF_0000; end
        6: begin set_all(8'($urandom), 8'($urandom),
                         $urandom_range(0, 20), $urandom_range(0, 100));
                 tx_pct = 71; rx_pct = 0; step_max = 12; end
        default: begin
                 set_all(8'($urandom), 8'($urandom),
                         $urandom_range(0, 40), $urandom_range(0, 400));
                 tx_pct = 0; rx_pct = 71; step_max = 60; end
      endcase
      tx_idle_pct  <= tx_pct;
      rx_stall_pct <= rx_pct;
      // hold the receiver off so the output backs up into the scan side
      if (phase == 4) begin
        fork
          begin
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_OFF) @(posedge clk);
            hold_on <= 1'b0;
          end
        join_none
      end
      @(negedge clk);
      for (int k = 0; k < n_items; k++) begin
        flip = 8'($urandom & $urandom & $urandom);
        if ($urandom_range(0, 99) < 10) lv = 8'($urandom);
        else lv = lv ^ flip;
        if ($urandom_range(0, 99) < 8) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, step_max);
        add_scan(lv, stamp);
      end
      drain();
    end

    if (due_alerts.size() != 0) begin
      $display("%0t: %0d expected alerts never arrived", $time, due_alerts.size());
      errors++;
    end
    $display("Run covered %0d scans over 9 register settings and 4 idling patterns,",
             scans_taken);
    $display("with %0d alerts checked and %0d mismatches.", alerts_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/edac_pkg.sv
rtl/edac_if.sv
rtl/edac_ctrl.sv
rtl/edac_dp.sv
rtl/digital_edge_alert_debounce_cooldown.sv
sim/digital_edge_alert_debounce_cooldown_tb.sv
